// File: hdl/lpcd_pkg.sv
// shared types and constants for the length-prefixed command deframer
`timescale 1ns / 1ps
`default_nettype none

package lpcd_pkg;

    localparam int unsigned POS_W       = 17;
    localparam int unsigned SIZE_W      = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned HDR_LEN     = 4;
    localparam int unsigned PADDR_W     = 3;
    localparam int unsigned PDATA_W     = 32;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 16'd1024;

    // register index taken from paddr[2]
    localparam logic REG_MAX_PAYLOAD_SIZE = 1'b0;

    // header byte positions
    localparam logic [POS_W-1:0] POS_ID      = 17'd0;
    localparam logic [POS_W-1:0] POS_SIZE_HI = 17'd1;
    localparam logic [POS_W-1:0] POS_SIZE_LO = 17'd2;
    localparam logic [POS_W-1:0] POS_CMD     = 17'd3;

    typedef enum logic [2:0] {
        ST_HEADER   = 3'd0,
        ST_PAYLOAD  = 3'd1,
        ST_COMPLETE = 3'd2,
        ST_SIZE_ERR = 3'd3,
        ST_DISCARD  = 3'd4
    } status_t;

    // classified item handed from front to back
    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   id;
        logic [BYTE_W-1:0]   cmd;
        logic [SIZE_W-1:0]   size;
        logic [BYTE_W-1:0]   data;
        logic [SIZE_W-1:0]   offset;
        logic                pvalid;
    } rec_t;

endpackage

`default_nettype wire

// File: hdl/lpcd_if.sv
// stream interfaces for received bytes and parse results
`timescale 1ns / 1ps
`default_nettype none

interface lpcd_byte_if;
    logic                          valid;
    logic                          ready;
    logic [lpcd_pkg::BYTE_W-1:0]   data_byte;
    logic                          chunk_start;

    modport source (output valid, output data_byte, output chunk_start, input ready);
    modport sink   (input valid, input data_byte, input chunk_start, output ready);
endinterface

interface lpcd_result_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [lpcd_pkg::BYTE_W-1:0]   message_id;
    logic [lpcd_pkg::BYTE_W-1:0]   command_code;
    logic [lpcd_pkg::SIZE_W-1:0]   frame_size;
    logic [lpcd_pkg::BYTE_W-1:0]   payload_value;
    logic [lpcd_pkg::SIZE_W-1:0]   payload_offset;
    logic                          payload_valid;

    modport source (output valid, output status, output message_id, output command_code,
                    output frame_size, output payload_value, output payload_offset,
                    output payload_valid, input ready);
    modport sink   (input valid, input status, input message_id, input command_code,
                    input frame_size, input payload_value, input payload_offset,
                    input payload_valid, output ready);
endinterface

`default_nettype wire

// File: hdl/length_prefixed_command_deframer_unit.sv
// top level of the length-prefixed command deframer
//
// byte_in carries one received byte per item with a chunk-start flag; result_out
// gives exactly one result per byte: header, payload (with offset), frame complete,
// size error or discarded, together with the held message id and command code.
// frames are id, size high, size low, command, then size payload bytes.
// the apb port holds one register, max_payload_size at address 0 (reset 1024);
// sizes above it raise a size error and the rest of the chunk is discarded.
// throughput is one byte per cycle while the queue has space: the next parse position,
// size compare and completion compare are all combinational in the front end.
// each accepted byte is written into the two-entry queue and then loaded into the
// output register, from which the receiver takes its result.
// when the receiver stalls, the output register holds its result and the queue
// absorbs up to two further bytes; byte_in.ready then drops until space frees.
// reset clears the parse state, empties the queue and clears the output valid flag,
// and restores the size limit to 1024.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_command_deframer_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    lpcd_byte_if.sink                          byte_in,
    lpcd_result_if.source                      result_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lpcd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [lpcd_pkg::PDATA_W-1:0]  pwdata,
    output      logic [lpcd_pkg::PDATA_W-1:0]  prdata,
    output      logic                          pready
);

    logic [lpcd_pkg::SIZE_W-1:0] max_size_reg, max_size_next;
    logic                        cfg_wr;
    logic                        q_full;
    logic                        q_push;
    lpcd_pkg::rec_t              q_push_rec;
    logic                        q_pop;
    logic                        q_pop_valid;
    lpcd_pkg::rec_t              q_pop_rec;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        max_size_next = max_size_reg;
        if (cfg_wr && paddr[2] == lpcd_pkg::REG_MAX_PAYLOAD_SIZE)
        begin
            max_size_next = pwdata[lpcd_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg <= lpcd_pkg::MAX_SIZE_RESET;
        end
        else
        begin
            max_size_reg <= max_size_next;
        end
    end

    always_comb
    begin
        if (paddr[2] == lpcd_pkg::REG_MAX_PAYLOAD_SIZE)
        begin
            prdata = {{(lpcd_pkg::PDATA_W - lpcd_pkg::SIZE_W){1'b0}}, max_size_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    lpcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_in),
        .max_size (max_size_reg),
        .q_full   (q_full),
        .push     (q_push),
        .push_rec (q_push_rec)
    );

    lpcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_rec  (q_push_rec),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_pop_valid),
        .pop_rec   (q_pop_rec)
    );

    lpcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_pop_valid),
        .q_rec      (q_pop_rec),
        .pop        (q_pop),
        .result_out (result_out)
    );

endmodule

`default_nettype wire

// File: hdl/lpcd_front.sv
// front end: holds parse state, accepts and classifies each received byte
`timescale 1ns / 1ps
`default_nettype none

module lpcd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    lpcd_byte_if.sink                          byte_in,
    input  wire logic [lpcd_pkg::SIZE_W-1:0]   max_size,
    input  wire logic                          q_full,
    output      logic                          push,
    output      lpcd_pkg::rec_t                push_rec
);

    logic [lpcd_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [lpcd_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [lpcd_pkg::BYTE_W-1:0] id_reg, id_next;
    logic [lpcd_pkg::BYTE_W-1:0] cmd_reg, cmd_next;
    logic                        discard_reg, discard_next;

    logic [lpcd_pkg::POS_W-1:0]  pos_eff;
    logic [lpcd_pkg::POS_W-1:0]  pos_inc;
    logic [lpcd_pkg::POS_W-1:0]  pay_off;
    logic                        discard_eff;
    lpcd_pkg::status_t           status;
    logic                        pvalid;

    assign byte_in.ready = !q_full;
    assign push          = byte_in.valid && byte_in.ready;

    always_comb
    begin
        // chunk start clears position and discard before the byte is parsed
        pos_eff      = byte_in.chunk_start ? '0 : pos_reg;
        discard_eff  = byte_in.chunk_start ? 1'b0 : discard_reg;
        pos_next     = pos_eff;
        discard_next = discard_eff;
        size_next    = size_reg;
        id_next      = id_reg;
        cmd_next     = cmd_reg;
        status       = lpcd_pkg::ST_HEADER;
        pvalid       = 1'b0;
        pay_off      = pos_eff - lpcd_pkg::POS_W'(lpcd_pkg::HDR_LEN);
        pos_inc      = pos_eff + lpcd_pkg::POS_W'(1);

        if (discard_eff)
        begin
            status = lpcd_pkg::ST_DISCARD;
        end
        else
        begin
            unique case (pos_eff)
                lpcd_pkg::POS_ID:      id_next = byte_in.data_byte;
                lpcd_pkg::POS_SIZE_HI: size_next = {byte_in.data_byte, 8'h00};
                lpcd_pkg::POS_SIZE_LO:
                begin
                    size_next = {size_reg[15:8], byte_in.data_byte};
                    if (size_next > max_size)
                    begin
                        status       = lpcd_pkg::ST_SIZE_ERR;
                        discard_next = 1'b1;
                    end
                end
                lpcd_pkg::POS_CMD:     cmd_next = byte_in.data_byte;
                default:
                begin
                    status = lpcd_pkg::ST_PAYLOAD;
                    pvalid = 1'b1;
                end
            endcase

            if (status == lpcd_pkg::ST_SIZE_ERR)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_inc;
                // frame done once the payload count meets the size
                if (pos_inc >= lpcd_pkg::POS_W'(lpcd_pkg::HDR_LEN) &&
                    (pos_inc - lpcd_pkg::POS_W'(lpcd_pkg::HDR_LEN)) == {1'b0, size_next})
                begin
                    pos_next = '0;
                    status   = lpcd_pkg::ST_COMPLETE;
                end
            end
        end
    end

    always_comb
    begin
        push_rec.status = status;
        push_rec.id     = id_next;
        push_rec.cmd    = cmd_next;
        push_rec.size   = size_next;
        push_rec.data   = byte_in.data_byte;
        push_rec.offset = pay_off[lpcd_pkg::SIZE_W-1:0];
        push_rec.pvalid = pvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            size_reg    <= '0;
            id_reg      <= '0;
            cmd_reg     <= '0;
            discard_reg <= 1'b0;
        end
        else if (push)
        begin
            pos_reg     <= pos_next;
            size_reg    <= size_next;
            id_reg      <= id_next;
            cmd_reg     <= cmd_next;
            discard_reg <= discard_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lpcd_queue.sv
// short register queue between the front and back ends
`timescale 1ns / 1ps
`default_nettype none

module lpcd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire lpcd_pkg::rec_t  push_rec,
    output      logic            full,
    input  wire logic            pop,
    output      logic            pop_valid,
    output      lpcd_pkg::rec_t  pop_rec
);

    lpcd_pkg::rec_t              entry_reg [lpcd_pkg::QUEUE_DEPTH];
    logic [lpcd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lpcd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lpcd_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        do_push, do_pop;

    assign full      = (count_reg == lpcd_pkg::QCNT_W'(lpcd_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_rec   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == lpcd_pkg::QPTR_W'(lpcd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + lpcd_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == lpcd_pkg::QPTR_W'(lpcd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + lpcd_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + lpcd_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - lpcd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lpcd_back.sv
// back end: formats each classified item into a result and holds it in the output register
`timescale 1ns / 1ps
`default_nettype none

module lpcd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire lpcd_pkg::rec_t  q_rec,
    output      logic            pop,
    lpcd_result_if.source        result_out
);

    logic                          valid_reg, valid_next;
    logic [2:0]                    status_reg, status_next;
    logic [lpcd_pkg::BYTE_W-1:0]   id_reg, id_next;
    logic [lpcd_pkg::BYTE_W-1:0]   cmd_reg, cmd_next;
    logic [lpcd_pkg::SIZE_W-1:0]   fsize_reg, fsize_next;
    logic [lpcd_pkg::BYTE_W-1:0]   pval_reg, pval_next;
    logic [lpcd_pkg::SIZE_W-1:0]   poff_reg, poff_next;
    logic                          pvalid_reg, pvalid_next;

    assign pop = q_valid && (!valid_reg || result_out.ready);

    always_comb
    begin
        status_next = q_rec.status;
        id_next     = q_rec.id;
        cmd_next    = q_rec.cmd;
        pvalid_next = q_rec.pvalid;
        // size only shown when the frame ends or is rejected
        case (q_rec.status) inside
            lpcd_pkg::ST_COMPLETE,
            lpcd_pkg::ST_SIZE_ERR: fsize_next = q_rec.size;
            default:               fsize_next = '0;
        endcase
        pval_next = q_rec.pvalid ? q_rec.data : '0;
        poff_next = q_rec.pvalid ? q_rec.offset : '0;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            id_reg     <= id_next;
            cmd_reg    <= cmd_next;
            fsize_reg  <= fsize_next;
            pval_reg   <= pval_next;
            poff_reg   <= poff_next;
            pvalid_reg <= pvalid_next;
        end
    end

    assign result_out.valid          = valid_reg;
    assign result_out.status         = status_reg;
    assign result_out.message_id     = id_reg;
    assign result_out.command_code   = cmd_reg;
    assign result_out.frame_size     = fsize_reg;
    assign result_out.payload_value  = pval_reg;
    assign result_out.payload_offset = poff_reg;
    assign result_out.payload_valid  = pvalid_reg;

endmodule

`default_nettype wire

// File: hdl/lpcd_checker.sv
// port-level checks on the deframer results, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module lpcd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [15:0] frame_size,
    input wire logic [7:0]  payload_value,
    input wire logic [15:0] payload_offset,
    input wire logic        payload_valid
);

    // a stalled result holds its status, frame size and payload offset
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_size)
            && $stable(payload_offset))
        else $error("stalled result changed");

    // payload bytes only on payload or complete results
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |->
            status == lpcd_pkg::ST_PAYLOAD || status == lpcd_pkg::ST_COMPLETE)
        else $error("payload flag on non-payload result");

    // a payload result always carries its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == lpcd_pkg::ST_PAYLOAD |-> payload_valid)
        else $error("payload result without payload flag");

    // size only shown on complete or size error, payload fields cleared when not valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == lpcd_pkg::ST_HEADER || status == lpcd_pkg::ST_PAYLOAD
            || status == lpcd_pkg::ST_DISCARD) |-> frame_size == '0)
        else $error("frame size shown outside frame end");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> payload_value == '0 && payload_offset == '0)
        else $error("payload fields set without payload flag");

endmodule

bind length_prefixed_command_deframer_unit lpcd_checker u_lpcd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result_out.valid),
    .out_ready      (result_out.ready),
    .status         (result_out.status),
    .frame_size     (result_out.frame_size),
    .payload_value  (result_out.payload_value),
    .payload_offset (result_out.payload_offset),
    .payload_valid  (result_out.payload_valid)
);

`default_nettype wire
